// ----- hdl/nps_pkg.sv -----
package nps_pkg;

  // Capacity of the point store
  localparam int MAX_PRIMARY = 64;
  localparam int MAX_IMAGES  = 64;

  // Field widths
  localparam int COORD_W = 24;
  localparam int IDX_W   = 6;
  localparam int DIST_W  = 52;
  localparam int ABS_W   = COORD_W;
  localparam int SQ_W    = 2 * ABS_W;

  // Counter and address widths
  localparam int PCNT_W   = $clog2(MAX_PRIMARY + 1);
  localparam int ICNT_W   = $clog2(MAX_IMAGES + 1);
  localparam int SCAN_W   = (PCNT_W > ICNT_W) ? PCNT_W : ICNT_W;
  localparam int PT_DEPTH = MAX_PRIMARY + MAX_IMAGES;
  localparam int PT_AW    = $clog2(PT_DEPTH);
  localparam int IMG_AW   = $clog2(MAX_IMAGES);

  localparam logic [DIST_W-1:0] DIST_ONES = {DIST_W{1'b1}};
  localparam logic [DIST_W-1:0] SEP_RESET = DIST_W'(167772);

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic                      is_image;
    logic [IDX_W-1:0]          owner_index;
    logic                      last_point;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]  point_index;
    logic [IDX_W-1:0]  neighbor_index;
    logic [DIST_W-1:0] neighbor_dist_sq;
    logic              found;
    logic [DIST_W-1:0] global_min_sq;
    logic              too_close;
    logic              last_result;
  } out_item_t;

  // One stored point
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  // Candidate tag that travels with the distance pipeline
  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] id;
  } cand_tag_t;

endpackage

// ----- hdl/nearest_point_search_top.sv -----
// Nearest point search over a loaded set of 3-D points.
// Input channel (in_valid_i/in_ready_o, in_data_i): points load one per cycle,
// primaries into the first half of the point memory, images into the second half
// with their owner index. last_point set starts the search if a primary is stored.
// Output channel (out_valid_o/out_ready_i, out_data_o): one result per stored
// primary, in index order; the last one has last_result set and carries too_close.
// Config channel (cfg_valid_i/cfg_ready_o, cfg_data_i): always ready, writes the
// squared minimum separation; write it only while the block is idle.
// The search uses the single read port of the point memory, one candidate per
// cycle, scanning the P primaries and then the I images for each primary.
// in_ready_o stays low during the search.
// Reset clears the counts and the running minimum, and restores the threshold;
// the memories keep their contents and need no clearing pass.
// A stalled receiver holds the search at the point where the next result is
// due; the pending result stays in the output register until it is taken.
module nearest_point_search_top import nps_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_item_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_item_t         out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [DIST_W-1:0] cfg_data_i
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FETCH = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [PCNT_W-1:0] pc_q, pc_d;
  logic [ICNT_W-1:0] ic_q, ic_d;
  logic [DIST_W-1:0] runmin_q, runmin_d;
  logic [DIST_W-1:0] sep_q;
  logic [IDX_W-1:0]  pidx_q, pidx_d;
  logic [SCAN_W-1:0] scan_q, scan_d;
  logic              img_ph_q, img_ph_d;
  logic [DIST_W-1:0] best_q, best_d;
  logic [IDX_W-1:0]  best_id_q, best_id_d;
  logic              found_q, found_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  // Memories and read stage
  point_t            pt_mem [PT_DEPTH];
  logic [IDX_W-1:0]  own_mem [MAX_IMAGES];
  point_t            rd_q, pi_q, wr_pt;
  logic [IDX_W-1:0]  own_q;
  logic [PT_AW-1:0]  rd_addr, wr_addr;
  logic [IMG_AW-1:0] own_wr_addr;
  logic              pt_we, own_we;
  logic              iss_vld, iss_self, iss_img;
  logic [IDX_W-1:0]  iss_idx;
  logic              rd_vld_q, rd_self_q, rd_img_q;
  logic [IDX_W-1:0]  rd_idx_q;

  // Distance pipeline
  cand_tag_t         cand_tag, dist_tag;
  logic [DIST_W-1:0] cand_dist;
  logic              dist_busy;

  // Emit helpers
  logic              in_fire, emit, emit_last, upd_min;
  logic [DIST_W-1:0] new_min;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i & in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign wr_pt       = '{x: in_data_i.pos_x, y: in_data_i.pos_y, z: in_data_i.pos_z};
  assign own_wr_addr = ic_q[IMG_AW-1:0];
  assign upd_min     = found_q && (best_q < runmin_q);
  assign new_min     = upd_min ? best_q : runmin_q;
  assign emit_last   = ((PCNT_W'(pidx_q) + PCNT_W'(1)) == pc_q);

  // Sequencer: load, then per primary fetch it, scan candidates, drain, emit
  always_comb begin
    state_d     = state_q;
    pc_d        = pc_q;
    ic_d        = ic_q;
    runmin_d    = runmin_q;
    pidx_d      = pidx_q;
    scan_d      = scan_q;
    img_ph_d    = img_ph_q;
    best_d      = best_q;
    best_id_d   = best_id_q;
    found_d     = found_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_d       = out_q;
    rd_addr     = PT_AW'(pidx_q);
    iss_vld     = 1'b0;
    iss_self    = 1'b0;
    iss_img     = 1'b0;
    iss_idx     = IDX_W'(scan_q);
    pt_we       = 1'b0;
    own_we      = 1'b0;
    wr_addr     = PT_AW'(pc_q);
    emit        = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_data_i.is_image) begin
            if (ic_q < ICNT_W'(MAX_IMAGES)) begin
              pt_we   = 1'b1;
              own_we  = 1'b1;
              wr_addr = PT_AW'(MAX_PRIMARY) + PT_AW'(ic_q);
              ic_d    = ic_q + ICNT_W'(1);
            end
          end else if (pc_q < PCNT_W'(MAX_PRIMARY)) begin
            pt_we = 1'b1;
            pc_d  = pc_q + PCNT_W'(1);
          end
          if (in_data_i.last_point) begin
            pidx_d = '0;
            if (pc_d != '0) begin
              state_d = ST_FETCH;
            end else begin
              ic_d = '0;
            end
          end
        end
      end
      ST_FETCH: begin
        iss_self  = 1'b1;
        scan_d    = '0;
        img_ph_d  = 1'b0;
        best_d    = DIST_ONES;
        best_id_d = '0;
        found_d   = 1'b0;
        state_d   = ST_SCAN;
      end
      ST_SCAN: begin
        if (!img_ph_q) begin
          if (scan_q < SCAN_W'(pc_q)) begin
            rd_addr = PT_AW'(scan_q);
            iss_vld = (scan_q != SCAN_W'(pidx_q));
            scan_d  = scan_q + SCAN_W'(1);
          end else begin
            img_ph_d = 1'b1;
            scan_d   = '0;
          end
        end else begin
          if (scan_q < SCAN_W'(ic_q)) begin
            rd_addr = PT_AW'(MAX_PRIMARY) + PT_AW'(scan_q);
            iss_vld = 1'b1;
            iss_img = 1'b1;
            scan_d  = scan_q + SCAN_W'(1);
          end else begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (!rd_vld_q && !dist_busy) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          emit                   = 1'b1;
          out_valid_d            = 1'b1;
          out_d.point_index      = pidx_q;
          out_d.neighbor_index   = best_id_q;
          out_d.neighbor_dist_sq = best_q;
          out_d.found            = found_q;
          out_d.global_min_sq    = new_min;
          out_d.too_close        = emit_last && (new_min < sep_q);
          out_d.last_result      = emit_last;
          if (emit_last) begin
            pc_d     = '0;
            ic_d     = '0;
            runmin_d = DIST_ONES;
            state_d  = ST_IDLE;
          end else begin
            runmin_d = new_min;
            pidx_d   = pidx_q + IDX_W'(1);
            state_d  = ST_FETCH;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Keep the first strictly smaller distance
    if (dist_tag.vld && (cand_dist < best_q)) begin
      best_d    = cand_dist;
      best_id_d = dist_tag.id;
      found_d   = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pc_q        <= '0;
      ic_q        <= '0;
      runmin_q    <= DIST_ONES;
      sep_q       <= SEP_RESET;
      pidx_q      <= '0;
      scan_q      <= '0;
      img_ph_q    <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
      rd_vld_q    <= 1'b0;
      rd_self_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      ic_q        <= ic_d;
      runmin_q    <= runmin_d;
      pidx_q      <= pidx_d;
      scan_q      <= scan_d;
      img_ph_q    <= img_ph_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
      rd_vld_q    <= iss_vld;
      rd_self_q   <= iss_self;
      if (cfg_valid_i && cfg_ready_o) begin
        sep_q <= cfg_data_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    best_q    <= best_d;
    best_id_q <= best_id_d;
    out_q     <= out_d;
    rd_img_q  <= iss_img;
    rd_idx_q  <= iss_idx;
    if (rd_self_q) begin
      pi_q <= rd_q;
    end
  end

  // Point memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (pt_we) begin
      pt_mem[wr_addr] <= wr_pt;
    end
    rd_q <= pt_mem[rd_addr];
  end

  // Image owner memory, read in step with the point memory
  always_ff @(posedge clk_i) begin
    if (own_we) begin
      own_mem[own_wr_addr] <= in_data_i.owner_index;
    end
    own_q <= own_mem[scan_q[IMG_AW-1:0]];
  end

  assign cand_tag.vld = rd_vld_q;
  assign cand_tag.id  = rd_img_q ? own_q : rd_idx_q;

  nps_dist u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pa_i   (pi_q),
    .pb_i   (rd_q),
    .tag_i  (cand_tag),
    .dist_o (cand_dist),
    .tag_o  (dist_tag),
    .busy_o (dist_busy)
  );

  // Counts stay within the store capacity
  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q <= PCNT_W'(MAX_PRIMARY)) && (ic_q <= ICNT_W'(MAX_IMAGES)))
    else $error("point count beyond capacity");

  // A search only runs with at least one stored primary
  a_search_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (pc_q != '0))
    else $error("search running with no primaries");

  // Distances arrive only while candidates are scanned or drained
  a_dist_window : assert property (@(posedge clk_i) disable iff (!rst_ni)
    dist_tag.vld |-> (state_q == ST_SCAN || state_q == ST_DRAIN))
    else $error("distance outside scan window");

  // The running minimum never exceeds a found distance that is reported
  a_min_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && found_q) |=> (out_q.global_min_sq <= out_q.neighbor_dist_sq))
    else $error("global minimum above neighbor distance");

  // The final result of a run restores the state, counts and running minimum
  a_run_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && emit_last) |=> (state_q == ST_IDLE && pc_q == '0 && ic_q == '0
                             && runmin_q == DIST_ONES))
    else $error("run end did not restore state");

endmodule

// ----- hdl/nps_dist.sv -----
module nps_dist import nps_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  point_t            pa_i,
  input  point_t            pb_i,
  input  cand_tag_t         tag_i,
  output logic [DIST_W-1:0] dist_o,
  output cand_tag_t         tag_o,
  output logic              busy_o
);

  logic signed [COORD_W:0] dx, dy, dz;
  logic [ABS_W-1:0]        ax, ay, az;
  logic [SQ_W-1:0]         sqx_q, sqy_q, sqz_q;
  logic [DIST_W-1:0]       dist_q;
  cand_tag_t               tag1_q, tag2_q;

  // Differences and magnitudes; the magnitude of a difference fits in ABS_W bits
  always_comb begin
    dx = (COORD_W+1)'(pa_i.x) - (COORD_W+1)'(pb_i.x);
    dy = (COORD_W+1)'(pa_i.y) - (COORD_W+1)'(pb_i.y);
    dz = (COORD_W+1)'(pa_i.z) - (COORD_W+1)'(pb_i.z);
    ax = dx[COORD_W] ? ABS_W'(-dx) : ABS_W'(dx);
    ay = dy[COORD_W] ? ABS_W'(-dy) : ABS_W'(dy);
    az = dz[COORD_W] ? ABS_W'(-dz) : ABS_W'(dz);
  end

  // Tags carry control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
    end else begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
    end
  end

  // Square, then sum
  always_ff @(posedge clk_i) begin
    sqx_q  <= SQ_W'(ax * ax);
    sqy_q  <= SQ_W'(ay * ay);
    sqz_q  <= SQ_W'(az * az);
    dist_q <= DIST_W'(sqx_q) + DIST_W'(sqy_q) + DIST_W'(sqz_q);
  end

  assign dist_o = dist_q;
  assign tag_o  = tag2_q;
  assign busy_o = tag1_q.vld | tag2_q.vld;

endmodule
